// ===== rtl/fps_pkg.sv =====
package fps_pkg;

  typedef enum logic [2:0] {
    PH_PRE     = 3'd0,
    PH_BURN    = 3'd1,
    PH_COAST   = 3'd2,
    PH_DESCENT = 3'd3,
    PH_STANDBY = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    REG_LAUNCH_ACCEL  = 3'd0,
    REG_BURNOUT_ACCEL = 3'd1,
    REG_MAIN_ALTITUDE = 3'd2,
    REG_PROCESS_NOISE = 3'd3,
    REG_MEAS_NOISE    = 3'd4,
    REG_INIT_UNCERT   = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_VDIV,
    ST_PREP,
    ST_KSTART,
    ST_KDIV,
    ST_MUL,
    ST_EMIT
  } ctl_state_e;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Uncertainty and measurement noise are Q8.16, process noise Q0.16; the gain is Q1.16 and reaches 1.0.
  localparam int Q_W    = 16;
  localparam int P_W    = 24;
  localparam int DEN_W  = P_W + 1;
  localparam int K_W    = 17;
  localparam int FRAC_W = 16;

  localparam logic [P_W-1:0]   P_MAX      = '1;
  localparam logic [K_W-1:0]   K_ONE      = 17'h10000;
  localparam logic [FRAC_W:0]  ROUND_HALF = 17'h08000;

  // Thresholds are held at least this wide so that their reset values fit.
  localparam int THR_MIN_W = 13;

  localparam int                 LAUNCH_RST  = 2560;
  localparam int                 BURNOUT_RST = 768;
  localparam int                 MAIN_RST    = 4500;
  localparam logic [Q_W-1:0]     QNOISE_RST  = 16'd655;
  localparam logic [P_W-1:0]     RNOISE_RST  = 24'd6554;
  localparam logic [P_W-1:0]     P0_RST      = 24'd65536;

  // Raw velocity is round(diff * 256 / 10): the top three numerator bits
  // always stay below the divisor, so they preload the remainder.
  localparam int               VDIV_PRE_W  = 3;
  localparam int               VEL_SHIFT   = 8;
  localparam logic [DEN_W-1:0] VEL_DIVISOR = 25'd10;
  localparam int               VEL_ROUND   = 5;

endpackage

// ===== rtl/fps_in_if.sv =====
interface fps_in_if #(
  parameter int ACCEL_BITS    = 16,
  parameter int ALTITUDE_BITS = 20
);
  logic                            valid;
  logic                            ready;
  logic signed [ACCEL_BITS-1:0]    accel_sample;
  logic signed [ALTITUDE_BITS-1:0] altitude_sample;

  modport source (output valid, output accel_sample, output altitude_sample, input ready);
  modport sink (input valid, input accel_sample, input altitude_sample, output ready);
endinterface

// ===== rtl/fps_out_if.sv =====
interface fps_out_if #(
  parameter int VELOCITY_BITS = 24
);
  logic                            valid;
  logic                            ready;
  logic [2:0]                      phase;
  logic                            drogue_fire;
  logic                            main_fire;
  logic                            transmit_request;
  logic signed [VELOCITY_BITS-1:0] filtered_velocity;
  logic                            velocity_valid;

  modport source (
    output valid, output phase, output drogue_fire, output main_fire,
    output transmit_request, output filtered_velocity, output velocity_valid,
    input ready
  );
  modport sink (
    input valid, input phase, input drogue_fire, input main_fire,
    input transmit_request, input filtered_velocity, input velocity_valid,
    output ready
  );
endinterface

// ===== rtl/fps_cfg_if.sv =====
interface fps_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fps_pkg::CFG_IDX_W-1:0]   index;
  logic [fps_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/fps_sdiv.sv =====
module fps_sdiv #(
  parameter int NUM_W = 26,
  parameter int DEN_W = 25
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [$clog2(NUM_W+1)-1:0]   steps_i,
  input  logic [DEN_W-1:0]             rem_init_i,
  input  logic [DEN_W-1:0]             den_i,
  input  logic [NUM_W-1:0]             num_i,
  output logic                         done_o,
  output logic [NUM_W-1:0]             quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  // Restoring division: quotient bits shift in at the bottom of the
  // numerator register as the numerator bits leave at the top.
  always_comb begin
    trial = {rem_q, num_q[NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    if (!diff[DEN_W]) begin
      rem_d = diff[DEN_W-1:0];
      num_d = {num_q[NUM_W-2:0], 1'b1};
    end else begin
      rem_d = trial[DEN_W-1:0];
      num_d = {num_q[NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_init_i;
      num_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      num_q <= num_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

// ===== rtl/fps_smul.sv =====
module fps_smul #(
  parameter int A_W = 25,
  parameter int B_W = 24,
  parameter int M_W = 17
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [A_W-1:0]       mcand_a_i,
  input  logic [M_W-1:0]       mplr_a_i,
  input  logic [B_W-1:0]       mcand_b_i,
  input  logic [M_W-1:0]       mplr_b_i,
  output logic                 done_o,
  output logic [A_W+M_W-1:0]   prod_a_o,
  output logic [B_W+M_W-1:0]   prod_b_o
);

  localparam int CNT_W = $clog2(M_W + 1);
  localparam int PA_W  = A_W + M_W;
  localparam int PB_W  = B_W + M_W;

  logic [A_W-1:0]   mcand_a_q;
  logic [B_W-1:0]   mcand_b_q;
  logic [M_W-1:0]   mplr_a_q;
  logic [M_W-1:0]   mplr_b_q;
  logic [PA_W-1:0]  acc_a_q, acc_a_d;
  logic [PB_W-1:0]  acc_b_q, acc_b_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  // Two shift-and-add products share one walk over the multiplier bits,
  // most significant bit first.
  always_comb begin
    acc_a_d = {acc_a_q[PA_W-2:0], 1'b0}
              + (mplr_a_q[M_W-1] ? PA_W'(mcand_a_q) : PA_W'(0));
    acc_b_d = {acc_b_q[PB_W-2:0], 1'b0}
              + (mplr_b_q[M_W-1] ? PB_W'(mcand_b_q) : PB_W'(0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(M_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_a_q <= mcand_a_i;
      mcand_b_q <= mcand_b_i;
      mplr_a_q  <= mplr_a_i;
      mplr_b_q  <= mplr_b_i;
      acc_a_q   <= '0;
      acc_b_q   <= '0;
    end else if (busy_q) begin
      mplr_a_q <= {mplr_a_q[M_W-2:0], 1'b0};
      mplr_b_q <= {mplr_b_q[M_W-2:0], 1'b0};
      acc_a_q  <= acc_a_d;
      acc_b_q  <= acc_b_d;
    end
  end

  assign done_o   = done_q;
  assign prod_a_o = acc_a_q;
  assign prod_b_o = acc_b_q;

endmodule

// ===== rtl/flight_phase_sequencer.sv =====
// Flight phase sequencer: one request on in_i is one sensor tick and yields
// one result on out_o. The phase moves pre-launch, burn, coast, descent,
// standby; in coast the altitude rate (Q.8) is smoothed by a scalar Kalman
// filter, and a filtered velocity at or below zero enters descent, which
// fires the drogue; the main chute fires at the main deploy altitude. Ticks
// that do not run the filter go from acceptance through the evaluate and
// emit states to the result register. A coast tick that runs the filter
// first takes the raw velocity from a bit-serial divider at one quotient
// bit per cycle (ALTITUDE_BITS + 6 steps); the gain uses the same divider
// for 17 steps, and the estimate and uncertainty updates share a 17-step
// serial multiplier. One tick is in work at a time; a new request is taken
// as soon as the previous result is in the output register, even while
// that result waits to be taken. Configuration writes are always accepted
// and take effect at once.
module flight_phase_sequencer #(
  parameter int ACCEL_BITS    = 16,
  parameter int ALTITUDE_BITS = 20,
  parameter int VELOCITY_BITS = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fps_cfg_if.sink   cfg_i,
  fps_in_if.sink    in_i,
  fps_out_if.source out_o
);

  localparam int AB    = ACCEL_BITS;
  localparam int HB    = ALTITUDE_BITS;
  localparam int VB    = VELOCITY_BITS;
  localparam int TW    = (AB > fps_pkg::THR_MIN_W) ? AB : fps_pkg::THR_MIN_W;
  localparam int MAW   = HB - 1;
  localparam int MW    = (MAW > fps_pkg::THR_MIN_W) ? MAW : fps_pkg::THR_MIN_W;
  localparam int CW    = ((HB > MW) ? HB : MW) + 1;
  localparam int DW    = HB + 1;
  localparam int VNW   = DW + fps_pkg::VEL_SHIFT;
  localparam int NUM_W = VNW - fps_pkg::VDIV_PRE_W;
  localparam int DCW   = $clog2(NUM_W + 1);
  localparam int RW    = NUM_W + VB;
  localparam int EW    = VB + 1;
  localparam int PA_W  = EW + fps_pkg::K_W;
  localparam int PB_W  = fps_pkg::P_W + fps_pkg::K_W;
  localparam int DM_W  = PA_W + 1 - fps_pkg::FRAC_W;
  localparam int XW    = DM_W + 2;

  localparam logic signed [RW-1:0] RAW_HI =
    $signed({{(RW-VB+1){1'b0}}, {(VB-1){1'b1}}});
  localparam logic signed [RW-1:0] RAW_LO = ~RAW_HI;
  localparam logic signed [XW-1:0] X_HI =
    $signed({{(XW-VB+1){1'b0}}, {(VB-1){1'b1}}});
  localparam logic signed [XW-1:0] X_LO = ~X_HI;

  fps_pkg::ctl_state_e state_q, state_d;

  // Configuration.
  logic signed [TW-1:0]           launch_q;
  logic signed [TW-1:0]           burnout_q;
  logic [MW-1:0]                  main_alt_q;
  logic [fps_pkg::Q_W-1:0]        qnoise_q;
  logic [fps_pkg::P_W-1:0]        rnoise_q;
  logic [fps_pkg::P_W-1:0]        p0_q;

  // Flight state.
  fps_pkg::phase_e                phase_q, phase_d;
  logic signed [HB-1:0]           prev_alt_q, prev_alt_d;
  logic                           alt_primed_q, alt_primed_d;
  logic signed [VB-1:0]           x_q;
  logic [fps_pkg::P_W-1:0]        p_q;
  logic                           filt_primed_q;
  logic                           drogue_q, drogue_d;
  logic                           main_q, main_d;
  logic                           tx;

  // Tick work registers.
  logic signed [AB-1:0]           accel_q;
  logic signed [HB-1:0]           alt_q;
  logic                           vneg_q;
  logic signed [VB-1:0]           raw_q;
  logic signed [VB-1:0]           xs_q;
  logic [fps_pkg::P_W-1:0]        ps_q;
  logic [EW-1:0]                  e_mag_q;
  logic                           e_neg_q;
  logic                           den_zero_q;

  // Result register.
  logic                           out_valid_q;
  fps_pkg::phase_e                out_phase_q;
  logic                           out_drogue_q;
  logic                           out_main_q;
  logic                           out_tx_q;
  logic signed [VB-1:0]           out_vel_q;
  logic                           out_vvalid_q;

  // Control strobes.
  logic in_fire, out_free, filter_tick;
  logic div_start, div_kmode, raw_load, prep_load, kstart_load;
  logic mul_start, filt_load, emit_fire;

  // Datapath.
  logic signed [DW-1:0]           diff;
  logic [DW-1:0]                  diff_mag;
  logic [VNW-1:0]                 vnum;
  logic [fps_pkg::DEN_W-1:0]      div_rem_init, div_den, kden;
  logic [NUM_W-1:0]               div_num, div_quot;
  logic [DCW-1:0]                 div_steps;
  logic                           div_done;
  logic signed [RW-1:0]           raw_wide;
  logic signed [VB-1:0]           raw_sat;
  logic signed [VB-1:0]           xs_d;
  logic [fps_pkg::P_W-1:0]        pbase;
  logic [fps_pkg::P_W:0]          psum;
  logic [fps_pkg::P_W-1:0]        ps_d;
  logic signed [EW-1:0]           err;
  logic [fps_pkg::K_W-1:0]        k_sel, kc;
  logic                           mul_done;
  logic [PA_W-1:0]                prod_a;
  logic [PB_W-1:0]                prod_b;
  logic [PA_W:0]                  prod_rnd;
  logic [DM_W-1:0]                dmag;
  logic signed [XW-1:0]           dstep, xsum;
  logic signed [VB-1:0]           x_new;
  logic signed [TW-1:0]           accel_ext;
  logic signed [CW-1:0]           alt_ext, main_ext;

  assign in_fire     = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;
  assign filter_tick = (phase_q == fps_pkg::PH_COAST) && alt_primed_q;

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fps_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    div_start   = 1'b0;
    div_kmode   = 1'b0;
    raw_load    = 1'b0;
    prep_load   = 1'b0;
    kstart_load = 1'b0;
    mul_start   = 1'b0;
    filt_load   = 1'b0;
    emit_fire   = 1'b0;
    unique case (state_q)
      fps_pkg::ST_IDLE: begin
        if (in_i.valid) state_d = fps_pkg::ST_EVAL;
      end
      fps_pkg::ST_EVAL: begin
        if (filter_tick) begin
          div_start = 1'b1;
          state_d   = fps_pkg::ST_VDIV;
        end else begin
          state_d = fps_pkg::ST_EMIT;
        end
      end
      fps_pkg::ST_VDIV: begin
        if (div_done) begin
          raw_load = 1'b1;
          state_d  = fps_pkg::ST_PREP;
        end
      end
      fps_pkg::ST_PREP: begin
        prep_load = 1'b1;
        state_d   = fps_pkg::ST_KSTART;
      end
      fps_pkg::ST_KSTART: begin
        div_start   = 1'b1;
        div_kmode   = 1'b1;
        kstart_load = 1'b1;
        state_d     = fps_pkg::ST_KDIV;
      end
      fps_pkg::ST_KDIV: begin
        if (div_done) begin
          mul_start = 1'b1;
          state_d   = fps_pkg::ST_MUL;
        end
      end
      fps_pkg::ST_MUL: begin
        if (mul_done) begin
          filt_load = 1'b1;
          state_d   = fps_pkg::ST_EMIT;
        end
      end
      fps_pkg::ST_EMIT: begin
        if (out_free) begin
          emit_fire = 1'b1;
          state_d   = fps_pkg::ST_IDLE;
        end
      end
      default: state_d = fps_pkg::ST_IDLE;
    endcase
  end

  // Raw velocity numerator: |diff| * 256 + 5, divided by 10 in the serial unit.
  always_comb begin
    diff     = $signed({alt_q[HB-1], alt_q}) - $signed({prev_alt_q[HB-1], prev_alt_q});
    diff_mag = diff[DW-1] ? DW'(-diff) : DW'(diff);
    vnum     = {diff_mag, {fps_pkg::VEL_SHIFT{1'b0}}} + VNW'(fps_pkg::VEL_ROUND);
    kden     = {1'b0, ps_q} + {1'b0, rnoise_q};
    if (div_kmode) begin
      // The gain never exceeds 1.0, so the upper quotient bits are zero and
      // the remainder starts from p / 2.
      div_rem_init = fps_pkg::DEN_W'(ps_q[fps_pkg::P_W-1:1]);
      div_num      = {ps_q[0], {(NUM_W-1){1'b0}}};
      div_den      = kden;
      div_steps    = DCW'(fps_pkg::K_W);
    end else begin
      div_rem_init = fps_pkg::DEN_W'(vnum[VNW-1 -: fps_pkg::VDIV_PRE_W]);
      div_num      = vnum[NUM_W-1:0];
      div_den      = fps_pkg::VEL_DIVISOR;
      div_steps    = DCW'(NUM_W);
    end
  end

  fps_sdiv #(
    .NUM_W (NUM_W),
    .DEN_W (fps_pkg::DEN_W)
  ) u_fps_sdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .steps_i    (div_steps),
    .rem_init_i (div_rem_init),
    .den_i      (div_den),
    .num_i      (div_num),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    raw_wide = vneg_q ? -$signed(RW'(div_quot)) : $signed(RW'(div_quot));
    if (raw_wide > RAW_HI) begin
      raw_sat = RAW_HI[VB-1:0];
    end else if (raw_wide < RAW_LO) begin
      raw_sat = RAW_LO[VB-1:0];
    end else begin
      raw_sat = raw_wide[VB-1:0];
    end
  end

  // Predict: the first filtered sample seeds the estimate and uncertainty.
  always_comb begin
    xs_d  = filt_primed_q ? x_q : raw_q;
    pbase = filt_primed_q ? p_q : p0_q;
    psum  = {1'b0, pbase} + (fps_pkg::P_W+1)'(qnoise_q);
    ps_d  = psum[fps_pkg::P_W] ? fps_pkg::P_MAX : psum[fps_pkg::P_W-1:0];
    err   = EW'(raw_q) - EW'(xs_q);
  end

  always_comb begin
    k_sel = den_zero_q ? '0 : div_quot[fps_pkg::K_W-1:0];
    kc    = fps_pkg::K_ONE - k_sel;
  end

  fps_smul #(
    .A_W (EW),
    .B_W (fps_pkg::P_W),
    .M_W (fps_pkg::K_W)
  ) u_fps_smul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .mcand_a_i (e_mag_q),
    .mplr_a_i  (k_sel),
    .mcand_b_i (ps_q),
    .mplr_b_i  (kc),
    .done_o    (mul_done),
    .prod_a_o  (prod_a),
    .prod_b_o  (prod_b)
  );

  // Update: x + round(k * e / 65536), rounded on the magnitude so that ties
  // go away from zero, then saturated.
  always_comb begin
    prod_rnd = (PA_W+1)'(prod_a) + (PA_W+1)'(fps_pkg::ROUND_HALF);
    dmag     = prod_rnd[PA_W:fps_pkg::FRAC_W];
    dstep    = e_neg_q ? -$signed(XW'(dmag)) : $signed(XW'(dmag));
    xsum     = XW'(xs_q) + dstep;
    if (xsum > X_HI) begin
      x_new = X_HI[VB-1:0];
    end else if (xsum < X_LO) begin
      x_new = X_LO[VB-1:0];
    end else begin
      x_new = xsum[VB-1:0];
    end
  end

  // Phase step, applied when the result is written.
  always_comb begin
    accel_ext    = TW'(accel_q);
    alt_ext      = CW'(alt_q);
    main_ext     = $signed(CW'(main_alt_q));
    phase_d      = phase_q;
    prev_alt_d   = prev_alt_q;
    alt_primed_d = alt_primed_q;
    drogue_d     = drogue_q;
    main_d       = main_q;
    tx           = 1'b0;
    unique case (phase_q)
      fps_pkg::PH_PRE: begin
        if (accel_ext > launch_q) phase_d = fps_pkg::PH_BURN;
      end
      fps_pkg::PH_BURN: begin
        if (accel_ext < burnout_q) phase_d = fps_pkg::PH_COAST;
      end
      fps_pkg::PH_COAST: begin
        prev_alt_d   = alt_q;
        alt_primed_d = 1'b1;
        if (alt_primed_q && (x_q[VB-1] || (x_q == '0))) phase_d = fps_pkg::PH_DESCENT;
      end
      fps_pkg::PH_DESCENT: begin
        drogue_d = 1'b1;
        if (!main_q && (alt_ext <= main_ext)) begin
          main_d  = 1'b1;
          phase_d = fps_pkg::PH_STANDBY;
        end
      end
      fps_pkg::PH_STANDBY: tx = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_q      <= TW'(fps_pkg::LAUNCH_RST);
      burnout_q     <= TW'(fps_pkg::BURNOUT_RST);
      main_alt_q    <= MW'(fps_pkg::MAIN_RST);
      qnoise_q      <= fps_pkg::QNOISE_RST;
      rnoise_q      <= fps_pkg::RNOISE_RST;
      p0_q          <= fps_pkg::P0_RST;
      phase_q       <= fps_pkg::PH_PRE;
      prev_alt_q    <= '0;
      alt_primed_q  <= 1'b0;
      x_q           <= '0;
      p_q           <= '0;
      filt_primed_q <= 1'b0;
      drogue_q      <= 1'b0;
      main_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        unique case (fps_pkg::cfg_reg_e'(cfg_i.index))
          fps_pkg::REG_LAUNCH_ACCEL:  launch_q   <= TW'($signed(cfg_i.data[AB-1:0]));
          fps_pkg::REG_BURNOUT_ACCEL: burnout_q  <= TW'($signed(cfg_i.data[AB-1:0]));
          fps_pkg::REG_MAIN_ALTITUDE: main_alt_q <= MW'(cfg_i.data[MAW-1:0]);
          fps_pkg::REG_PROCESS_NOISE: qnoise_q   <= cfg_i.data[fps_pkg::Q_W-1:0];
          fps_pkg::REG_MEAS_NOISE:    rnoise_q   <= cfg_i.data[fps_pkg::P_W-1:0];
          fps_pkg::REG_INIT_UNCERT:   p0_q       <= cfg_i.data[fps_pkg::P_W-1:0];
          default: ;
        endcase
      end
      if (filt_load) begin
        x_q           <= x_new;
        p_q           <= prod_b[fps_pkg::FRAC_W +: fps_pkg::P_W];
        filt_primed_q <= 1'b1;
      end
      if (emit_fire) begin
        phase_q      <= phase_d;
        prev_alt_q   <= prev_alt_d;
        alt_primed_q <= alt_primed_d;
        drogue_q     <= drogue_d;
        main_q       <= main_d;
        out_valid_q  <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      accel_q <= in_i.accel_sample;
      alt_q   <= in_i.altitude_sample;
    end
    if (div_start && !div_kmode) vneg_q <= diff[DW-1];
    if (raw_load) raw_q <= raw_sat;
    if (prep_load) begin
      xs_q <= xs_d;
      ps_q <= ps_d;
    end
    if (kstart_load) begin
      e_mag_q    <= err[EW-1] ? EW'(-err) : EW'(err);
      e_neg_q    <= err[EW-1];
      den_zero_q <= (kden == '0);
    end
    if (emit_fire) begin
      out_phase_q  <= phase_d;
      out_drogue_q <= drogue_d;
      out_main_q   <= main_d;
      out_tx_q     <= tx;
      out_vel_q    <= x_q;
      out_vvalid_q <= filter_tick;
    end
  end

  assign cfg_i.ready             = 1'b1;
  assign in_i.ready              = (state_q == fps_pkg::ST_IDLE);
  assign out_o.valid             = out_valid_q;
  assign out_o.phase             = out_phase_q;
  assign out_o.drogue_fire       = out_drogue_q;
  assign out_o.main_fire         = out_main_q;
  assign out_o.transmit_request  = out_tx_q;
  assign out_o.filtered_velocity = out_vel_q;
  assign out_o.velocity_valid    = out_vvalid_q;

endmodule

// ===== rtl/fps_checker.sv =====
module fps_checker #(
  parameter int VELOCITY_BITS = 24
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [2:0]                      phase_i,
  input logic                            drogue_fire_i,
  input logic                            main_fire_i,
  input logic                            transmit_request_i,
  input logic signed [VELOCITY_BITS-1:0] filtered_velocity_i,
  input logic                            velocity_valid_i
);

  a_stall_holds_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result request dropped while stalled");

  a_stall_holds_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(phase_i) && $stable(filtered_velocity_i)
      && $stable(drogue_fire_i) && $stable(main_fire_i))
    else $error("result payload changed while stalled");

  // The main chute only fires in standby, after the drogue.
  a_main_in_standby: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && main_fire_i |-> drogue_fire_i && (phase_i == fps_pkg::PH_STANDBY))
    else $error("main chute fired outside standby or before drogue");

  a_tx_after_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && transmit_request_i |-> main_fire_i)
    else $error("transmit requested before main chute");

  // A filter update happens only on a coast tick, which can at most enter descent.
  a_filter_in_coast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && velocity_valid_i |->
      ((phase_i == fps_pkg::PH_COAST) || (phase_i == fps_pkg::PH_DESCENT)) && !drogue_fire_i)
    else $error("velocity update outside coast");

endmodule

bind flight_phase_sequencer fps_checker #(
  .VELOCITY_BITS (VELOCITY_BITS)
) u_fps_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .phase_i             (out_o.phase),
  .drogue_fire_i       (out_o.drogue_fire),
  .main_fire_i         (out_o.main_fire),
  .transmit_request_i  (out_o.transmit_request),
  .filtered_velocity_i (out_o.filtered_velocity),
  .velocity_valid_i    (out_o.velocity_valid)
);

// ===== tb/sv/flight_phase_sequencer_tb.sv =====
`timescale 1ns / 100ps

module flight_phase_sequencer_tb;

  localparam int ACCEL_W = 16;
  localparam int ALT_W = 20;
  localparam int VEL_W = 24;
  localparam int ACCEL_MIN = -32768;
  localparam int ACCEL_MAX = 32767;
  localparam int ALT_MIN = -524288;
  localparam int ALT_MAX = 524287;
  localparam longint VEL_MAX = 64'sd8388607;
  localparam longint VEL_MIN = -64'sd8388608;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam int COAST_STAGE_ITEMS = 260;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct {
    logic signed [ACCEL_W-1:0] accel;
    logic signed [ALT_W-1:0]   altitude;
  } sample_t;

  typedef struct {
    logic [2:0]              phase;
    logic                    drogue;
    logic                    main_chute;
    logic                    transmit;
    logic signed [VEL_W-1:0] velocity;
    logic                    velocity_valid;
  } telemetry_t;

  typedef struct {
    fps_pkg::phase_e         phase;
    logic signed [ALT_W-1:0] prev_alt;
    logic                    alt_primed;
    longint                  velocity;
    longint unsigned         uncertainty;
    logic                    filter_primed;
    logic                    drogue;
    logic                    main_chute;
  } flight_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  fps_cfg_if cfg_if ();
  fps_in_if #(.ACCEL_BITS(ACCEL_W), .ALTITUDE_BITS(ALT_W)) in_if ();
  fps_out_if #(.VELOCITY_BITS(VEL_W)) out_if ();

  flight_phase_sequencer #(
    .ACCEL_BITS(ACCEL_W),
    .ALTITUDE_BITS(ALT_W),
    .VELOCITY_BITS(VEL_W)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Register shadow, kept in step with every configuration write.
  logic signed [ACCEL_W-1:0]   launch_thr = 16'(fps_pkg::LAUNCH_RST);
  logic signed [ACCEL_W-1:0]   burnout_thr = 16'(fps_pkg::BURNOUT_RST);
  logic [ALT_W-2:0]            main_alt = 19'(fps_pkg::MAIN_RST);
  logic [fps_pkg::Q_W-1:0]     q_noise = fps_pkg::QNOISE_RST;
  logic [fps_pkg::P_W-1:0]     r_noise = fps_pkg::RNOISE_RST;
  logic [fps_pkg::P_W-1:0]     p_init = fps_pkg::P0_RST;

  flight_t    flight;
  sample_t    sample_queue[$];
  telemetry_t telemetry_queue[$];
  sample_t    next_sample;
  idle_mode_e idle_mode;
  logic       hold_request;
  logic       hold_taken;
  int         hold_left;
  int         fail_count = 0;
  int         cycle_count = 0;

  function automatic longint sat_velocity(longint v);
    if (v > VEL_MAX) return VEL_MAX;
    if (v < VEL_MIN) return VEL_MIN;
    return v;
  endfunction

  // Rounds to nearest with ties away from zero; den is positive.
  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint quo;
    mag = (num < 0) ? -num : num;
    quo = (mag + den / 2) / den;
    return (num < 0) ? -quo : quo;
  endfunction

  function automatic void advance_flight(inout flight_t s, input sample_t smp,
                                         output telemetry_t t);
    longint          raw;
    longint unsigned p;
    longint unsigned den;
    longint unsigned k;
    logic            filtered;
    logic            transmit;
    filtered = 1'b0;
    transmit = 1'b0;
    case (s.phase)
      fps_pkg::PH_PRE: begin
        if (smp.accel > launch_thr) s.phase = fps_pkg::PH_BURN;
      end
      fps_pkg::PH_BURN: begin
        if (smp.accel < burnout_thr) s.phase = fps_pkg::PH_COAST;
      end
      fps_pkg::PH_COAST: begin
        if (!s.alt_primed) begin
          s.prev_alt = smp.altitude;
          s.alt_primed = 1'b1;
        end else begin
          raw = sat_velocity(round_div(
              (longint'(smp.altitude) - longint'(s.prev_alt)) * 256, 10));
          s.prev_alt = smp.altitude;
          if (!s.filter_primed) begin
            s.velocity = raw;
            s.uncertainty = p_init;
            s.filter_primed = 1'b1;
          end
          p = s.uncertainty + q_noise;
          if (p > fps_pkg::P_MAX) p = fps_pkg::P_MAX;
          den = p + r_noise;
          k = (den != 0) ? (p << 16) / den : 0;
          s.velocity = sat_velocity(s.velocity +
              round_div((raw - s.velocity) * longint'(k), 65536));
          s.uncertainty = ((65536 - k) * p) >> 16;
          filtered = 1'b1;
          if (s.velocity <= 0) s.phase = fps_pkg::PH_DESCENT;
        end
      end
      fps_pkg::PH_DESCENT: begin
        s.drogue = 1'b1;
        if (!s.main_chute && longint'(smp.altitude) <= longint'(main_alt)) begin
          s.main_chute = 1'b1;
          s.phase = fps_pkg::PH_STANDBY;
        end
      end
      fps_pkg::PH_STANDBY: begin
        transmit = 1'b1;
      end
      default: begin
      end
    endcase
    t.phase = s.phase;
    t.drogue = s.drogue;
    t.main_chute = s.main_chute;
    t.transmit = transmit;
    t.velocity = s.velocity[VEL_W-1:0];
    t.velocity_valid = filtered;
  endfunction

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(99) < 88;
      IDLE_BOTH:   return $urandom_range(99) < 37;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(99) < 88;
      IDLE_BOTH:     return $urandom_range(99) < 37;
      default:       return 1'b0;
    endcase
  endfunction

  // Tries a coast altitude on a copy of the flight state.
  function automatic bit descends_on(int altitude);
    flight_t    trial;
    sample_t    smp;
    telemetry_t t;
    trial = flight;
    smp.accel = '0;
    smp.altitude = altitude[ALT_W-1:0];
    advance_flight(trial, smp, t);
    return trial.phase == fps_pkg::PH_DESCENT;
  endfunction

  task automatic push_tick(int accel, int altitude);
    sample_t    smp;
    telemetry_t t;
    smp.accel = accel[ACCEL_W-1:0];
    smp.altitude = altitude[ALT_W-1:0];
    advance_flight(flight, smp, t);
    sample_queue = {sample_queue, smp};
    telemetry_queue = {telemetry_queue, t};
  endtask

  // Climbing coast tick with some jitter; a step that would end the climb
  // early is replaced by a firm rise.
  task automatic push_climb();
    int step;
    int next;
    step = ($urandom_range(9) == 0) ? rand_between(-5000, 5000) : rand_between(-300, 600);
    next = int'(flight.prev_alt) + step;
    if (next > ALT_MAX) next = ALT_MAX;
    if (descends_on(next)) begin
      next = int'(flight.prev_alt) + rand_between(300, 600);
      if (next > ALT_MAX) next = ALT_MAX;
    end
    push_tick(rand_between(ACCEL_MIN, ACCEL_MAX), next);
  endtask

  task automatic wait_idle();
    while (sample_queue.size() != 0 || telemetry_queue.size() != 0) @(posedge clk_i);
  endtask

  // Leaves valid high; the caller lowers it after the last write of a group.
  task automatic write_reg(fps_pkg::cfg_reg_e idx, logic [fps_pkg::CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      fps_pkg::REG_LAUNCH_ACCEL:  launch_thr = value[ACCEL_W-1:0];
      fps_pkg::REG_BURNOUT_ACCEL: burnout_thr = value[ACCEL_W-1:0];
      fps_pkg::REG_MAIN_ALTITUDE: main_alt = value[ALT_W-2:0];
      fps_pkg::REG_PROCESS_NOISE: q_noise = value[fps_pkg::Q_W-1:0];
      fps_pkg::REG_MEAS_NOISE:    r_noise = value[fps_pkg::P_W-1:0];
      fps_pkg::REG_INIT_UNCERT:   p_init = value[fps_pkg::P_W-1:0];
      default: begin
      end
    endcase
  endtask

  task automatic check_telemetry();
    telemetry_t exp;
    if (telemetry_queue.size() == 0) begin
      $error("unexpected result: phase %0d", out_if.phase);
      fail_count++;
      return;
    end
    exp = telemetry_queue.pop_front();
    if (out_if.phase !== exp.phase) begin
      $error("phase: expected %0d, actual %0d", exp.phase, out_if.phase);
      fail_count++;
    end
    if (out_if.drogue_fire !== exp.drogue) begin
      $error("drogue_fire: expected %0d, actual %0d", exp.drogue, out_if.drogue_fire);
      fail_count++;
    end
    if (out_if.main_fire !== exp.main_chute) begin
      $error("main_fire: expected %0d, actual %0d", exp.main_chute, out_if.main_fire);
      fail_count++;
    end
    if (out_if.transmit_request !== exp.transmit) begin
      $error("transmit_request: expected %0d, actual %0d", exp.transmit,
             out_if.transmit_request);
      fail_count++;
    end
    if (out_if.filtered_velocity !== exp.velocity) begin
      $error("filtered_velocity: expected %0d, actual %0d", exp.velocity,
             out_if.filtered_velocity);
      fail_count++;
    end
    if (out_if.velocity_valid !== exp.velocity_valid) begin
      $error("velocity_valid: expected %0d, actual %0d", exp.velocity_valid,
             out_if.velocity_valid);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.accel_sample <= '0;
      in_if.altitude_sample <= '0;
    end else if (!in_if.valid || in_if.ready) begin
      if (sample_queue.size() != 0 && !sender_idles()) begin
        next_sample = sample_queue.pop_front();
        in_if.valid <= 1'b1;
        in_if.accel_sample <= next_sample.accel;
        in_if.altitude_sample <= next_sample.altitude;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // The long hold is counted here so that the sender keeps offering requests
  // while the block backs up.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_left <= 0;
      hold_taken <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) check_telemetry();
      if (hold_request && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !receiver_stalls();
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int stage;
    int guard;
    rst_ni = 1'b0;
    idle_mode = IDLE_NONE;
    hold_request = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    in_if.valid = 1'b0;
    in_if.accel_sample = '0;
    in_if.altitude_sample = '0;
    out_if.ready = 1'b0;
    flight.phase = fps_pkg::PH_PRE;
    flight.prev_alt = '0;
    flight.alt_primed = 1'b0;
    flight.velocity = 0;
    flight.uncertainty = 0;
    flight.filter_primed = 1'b0;
    flight.drogue = 1'b0;
    flight.main_chute = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Pre-launch at the reset thresholds, including an acceleration equal to
    // the launch threshold.
    push_tick(ACCEL_MIN, ALT_MIN);
    push_tick(fps_pkg::LAUNCH_RST, ALT_MAX);
    push_tick(0, 0);
    wait_idle();
    write_reg(fps_pkg::REG_LAUNCH_ACCEL, 32'(16'h7FFF));
    cfg_if.valid <= 1'b0;
    push_tick(ACCEL_MAX, rand_between(ALT_MIN, ALT_MAX));
    wait_idle();
    write_reg(fps_pkg::REG_LAUNCH_ACCEL, 32'(16'h8000));
    cfg_if.valid <= 1'b0;
    push_tick(ACCEL_MIN, ALT_MAX);
    wait_idle();
    write_reg(fps_pkg::REG_LAUNCH_ACCEL, 32'(16'(rand_between(-2000, 8000))));
    write_reg(fps_pkg::REG_BURNOUT_ACCEL, 32'(16'h8000));
    write_reg(fps_pkg::REG_INIT_UNCERT, 32'(fps_pkg::P_MAX));
    cfg_if.valid <= 1'b0;

    idle_mode = IDLE_SENDER;
    repeat (150) push_tick(rand_between(ACCEL_MIN, int'(launch_thr)),
                           rand_between(ALT_MIN, ALT_MAX));
    push_tick(int'(launch_thr) + 1, rand_between(ALT_MIN, ALT_MAX));

    // Burn with the lowest burnout threshold cannot end.
    idle_mode = IDLE_RECEIVER;
    repeat (100) push_tick(rand_between(ACCEL_MIN, ACCEL_MAX),
                           rand_between(ALT_MIN, ALT_MAX));
    wait_idle();
    write_reg(fps_pkg::REG_BURNOUT_ACCEL, 32'(16'h7FFF));
    cfg_if.valid <= 1'b0;
    push_tick(ACCEL_MAX, rand_between(ALT_MIN, ALT_MAX));
    wait_idle();
    write_reg(fps_pkg::REG_BURNOUT_ACCEL, 32'(16'(rand_between(-1000, 3000))));
    cfg_if.valid <= 1'b0;
    idle_mode = IDLE_BOTH;
    repeat (100) push_tick(rand_between(int'(burnout_thr), ACCEL_MAX),
                           rand_between(ALT_MIN, ALT_MAX));
    push_tick(int'(burnout_thr) - 1, rand_between(ALT_MIN, ALT_MAX));
    wait_idle();

    // Coast starts from the lowest altitude and jumps far enough to
    // saturate the raw velocity, which also starts the filter at the
    // largest uncertainty.
    idle_mode = IDLE_NONE;
    hold_request = 1'b1;
    push_tick(rand_between(ACCEL_MIN, ACCEL_MAX), ALT_MIN);
    push_tick(rand_between(ACCEL_MIN, ACCEL_MAX), ALT_MIN + 327681);
    repeat (COAST_STAGE_ITEMS) push_climb();

    for (stage = 1; stage < 5; stage++) begin
      wait_idle();
      case (stage)
        1: begin
          write_reg(fps_pkg::REG_PROCESS_NOISE, 32'd0);
          write_reg(fps_pkg::REG_MEAS_NOISE, 32'(fps_pkg::P_MAX));
          idle_mode = IDLE_SENDER;
        end
        2: begin
          write_reg(fps_pkg::REG_PROCESS_NOISE, 32'($urandom_range(65535)));
          write_reg(fps_pkg::REG_MEAS_NOISE, 32'($urandom_range(16777215, 1)));
          idle_mode = IDLE_RECEIVER;
        end
        3: begin
          write_reg(fps_pkg::REG_PROCESS_NOISE, 32'($urandom_range(65535)));
          write_reg(fps_pkg::REG_MEAS_NOISE, 32'($urandom_range(200000, 1)));
          idle_mode = IDLE_BOTH;
        end
        default: begin
          write_reg(fps_pkg::REG_PROCESS_NOISE, 32'($urandom_range(65535)));
          write_reg(fps_pkg::REG_MEAS_NOISE, 32'($urandom_range(2000, 1)));
          idle_mode = IDLE_NONE;
        end
      endcase
      cfg_if.valid <= 1'b0;
      repeat (COAST_STAGE_ITEMS) push_climb();
    end

    // With the largest process noise and the smallest measurement noise the
    // gain is close to one, so a fall to the lowest altitude turns the
    // estimate negative.
    wait_idle();
    write_reg(fps_pkg::REG_PROCESS_NOISE, 32'(16'hFFFF));
    write_reg(fps_pkg::REG_MEAS_NOISE, 32'd1);
    write_reg(fps_pkg::REG_MAIN_ALTITUDE, 32'd0);
    cfg_if.valid <= 1'b0;
    guard = 0;
    while (flight.phase == fps_pkg::PH_COAST && guard < 20) begin
      push_tick(rand_between(ACCEL_MIN, ACCEL_MAX), ALT_MIN);
      guard++;
    end

    // Descent above a zero deploy altitude, starting one decimetre above it.
    idle_mode = IDLE_SENDER;
    push_tick(rand_between(ACCEL_MIN, ACCEL_MAX), 1);
    repeat (100) push_tick(rand_between(ACCEL_MIN, ACCEL_MAX), rand_between(1, ALT_MAX));
    wait_idle();
    write_reg(fps_pkg::REG_MAIN_ALTITUDE, 32'(19'h7FFFF));
    cfg_if.valid <= 1'b0;
    push_tick(rand_between(ACCEL_MIN, ACCEL_MAX), ALT_MAX);

    idle_mode = IDLE_BOTH;
    repeat (150) push_tick(rand_between(ACCEL_MIN, ACCEL_MAX),
                           rand_between(ALT_MIN, ALT_MAX));

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fps_pkg.sv
rtl/fps_in_if.sv
rtl/fps_out_if.sv
rtl/fps_cfg_if.sv
rtl/fps_sdiv.sv
rtl/fps_smul.sv
rtl/flight_phase_sequencer.sv
rtl/fps_checker.sv
tb/sv/flight_phase_sequencer_tb.sv
